>>> src/tccw_pkg.sv
// Shared constants and types for the text console cell writer.
package tccw_pkg;

    localparam int COLUMNS       = 64;
    localparam int LINES         = 32;
    localparam int DEFAULT_COLOR = 7;

    localparam int CELLS  = COLUMNS * LINES;
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int LINE_W = $clog2(LINES);
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CELL_W = 12;

    localparam int KIND_W     = 2;
    localparam int CHAR_W     = 8;
    localparam int COLOR_W    = 4;
    localparam int POS_COL_W  = 7;
    localparam int POS_ROW_W  = 6;

    localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MOVE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd3;

    localparam logic [CHAR_W-1:0] NUL_CODE     = 8'h00;
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;

    localparam logic [COLOR_W-1:0] COLOR_RESET = COLOR_W'(DEFAULT_COLOR);
    localparam logic [CELL_W-1:0]  BLANK_CELL  = {COLOR_RESET, SPACE_CODE};

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic                 load;
        logic                 from_ram;
        logic                 rejected;
        logic [POS_COL_W-1:0] col;
        logic [POS_ROW_W-1:0] row;
    } result_t;

endpackage

>>> src/text_console_cell_writer_core.sv
// Top level of the text console cell writer: color register, result register, cell store.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  cfg     | cfg_valid, cfg_ready, cfg_data             | in
//  in      | in_valid, in_ready, kind, char_code,       | in
//          | col_pos, row_pos                           |
//  out     | out_valid, out_ready, cursor_col,          | out
//          | cursor_row, cell_char, cell_color, rejected|
//
// Put-char, move and out-of-range read transactions can stream back to back. An
// in-range read holds off input while it waits in ST_READ for the store's registered read port.
// Reset and every clear transaction start a sweep over all COLUMNS*LINES (2048) cells that
// writes each cell once; input is held off during the sweep, configuration is not.
// A stalled result register holds off input until the result is taken.
module text_console_cell_writer_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tccw_pkg::COLOR_W-1:0]   cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [tccw_pkg::KIND_W-1:0]    kind,
    input  logic [tccw_pkg::CHAR_W-1:0]    char_code,
    input  logic [tccw_pkg::POS_COL_W-1:0] col_pos,
    input  logic [tccw_pkg::POS_ROW_W-1:0] row_pos,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [tccw_pkg::POS_COL_W-1:0] cursor_col,
    output logic [tccw_pkg::POS_ROW_W-1:0] cursor_row,
    output logic [tccw_pkg::CHAR_W-1:0]    cell_char,
    output logic [tccw_pkg::COLOR_W-1:0]   cell_color,
    output logic                           rejected
);
    import tccw_pkg::*;

    logic [COLOR_W-1:0]   fg_color_reg;
    logic                 out_valid_reg;
    logic [POS_COL_W-1:0] cursor_col_reg;
    logic [POS_ROW_W-1:0] cursor_row_reg;
    logic [CHAR_W-1:0]    cell_char_reg;
    logic [COLOR_W-1:0]   cell_color_reg;
    logic                 rejected_reg;

    logic              out_free;
    mem_req_t          req;
    result_t           res;
    logic [CELL_W-1:0] rdata;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;

    tccw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .char_code (char_code),
        .col_pos   (col_pos),
        .row_pos   (row_pos),
        .fg_color  (fg_color_reg),
        .out_free  (out_free),
        .req       (req),
        .res       (res)
    );

    tccw_cell_ram u_ram (
        .clk   (clk),
        .req   (req),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_color_reg  <= COLOR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                fg_color_reg <= cfg_data;
            end
            if (res.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.load)
        begin
            cursor_col_reg <= res.col;
            cursor_row_reg <= res.row;
            rejected_reg   <= res.rejected;
            cell_char_reg  <= res.from_ram ? rdata[CHAR_W-1:0] : '0;
            cell_color_reg <= res.from_ram ? rdata[CELL_W-1:CHAR_W] : '0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cursor_col = cursor_col_reg;
    assign cursor_row = cursor_row_reg;
    assign cell_char  = cell_char_reg;
    assign cell_color = cell_color_reg;
    assign rejected   = rejected_reg;

endmodule

>>> src/tccw_cell_ram.sv
// Character cell store: one write port and one registered read port.
module tccw_cell_ram (
    input  logic                        clk,
    input  tccw_pkg::mem_req_t          req,
    output logic [tccw_pkg::CELL_W-1:0] rdata
);
    import tccw_pkg::*;

    logic [CELL_W-1:0] mem [CELLS];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata <= mem[req.raddr];
    end

endmodule

>>> src/tccw_ctrl.sv
// Sequencer: cursor, item decode, clearing sweep and cell store requests.
module tccw_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [tccw_pkg::KIND_W-1:0]    kind,
    input  logic [tccw_pkg::CHAR_W-1:0]    char_code,
    input  logic [tccw_pkg::POS_COL_W-1:0] col_pos,
    input  logic [tccw_pkg::POS_ROW_W-1:0] row_pos,
    input  logic [tccw_pkg::COLOR_W-1:0]   fg_color,
    input  logic                           out_free,
    output tccw_pkg::mem_req_t             req,
    output tccw_pkg::result_t              res
);
    import tccw_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;

    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
    localparam logic [LINE_W-1:0] LAST_LINE = LINE_W'(LINES - 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);

    logic [1:0]        state_reg, state_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic [ADDR_W-1:0] sweep_reg, sweep_next;

    logic              accept;
    logic              pos_ok;
    logic [CHAR_W-1:0] put_code;

    assign in_ready = (state_reg == ST_RUN) && out_free;
    assign accept   = in_valid && in_ready;
    assign put_code = (char_code == NUL_CODE) ? SPACE_CODE : char_code;
    assign pos_ok   = (col_pos != '0) && (8'(col_pos) <= 8'(COLUMNS)) &&
                      (row_pos != '0) && (7'(row_pos) <= 7'(LINES));

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        line_next  = line_reg;
        sweep_next = sweep_reg;

        req.we    = 1'b0;
        req.waddr = ADDR_W'(line_reg) * ADDR_W'(COLUMNS) + ADDR_W'(col_reg);
        req.wdata = {fg_color, put_code};
        req.raddr = ADDR_W'(row_pos - 6'd1) * ADDR_W'(COLUMNS) + ADDR_W'(col_pos - 7'd1);

        res.load     = 1'b0;
        res.from_ram = 1'b0;
        res.rejected = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                req.we    = 1'b1;
                req.waddr = sweep_reg;
                req.wdata = BLANK_CELL;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == LAST_ADDR)
                begin
                    sweep_next = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (accept)
                begin
                    res.load = 1'b1;
                    case (kind)
                        KIND_PUT:
                        begin
                            if (put_code == NEWLINE_CODE)
                            begin
                                col_next = '0;
                                if (line_reg != LAST_LINE)
                                begin
                                    line_next = line_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                req.we = 1'b1;
                                if (col_reg != LAST_COL)
                                begin
                                    col_next = col_reg + 1'b1;
                                end
                                else if (line_reg != LAST_LINE)
                                begin
                                    col_next  = '0;
                                    line_next = line_reg + 1'b1;
                                end
                            end
                        end
                        KIND_MOVE:
                        begin
                            if (pos_ok)
                            begin
                                col_next  = COL_W'(col_pos - 7'd1);
                                line_next = LINE_W'(row_pos - 6'd1);
                            end
                            else
                            begin
                                res.rejected = 1'b1;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            col_next   = '0;
                            line_next  = '0;
                            state_next = ST_CLEAR;
                        end
                        KIND_READ:
                        begin
                            if (pos_ok)
                            begin
                                // The cell comes out of the store's registered read port in ST_READ.
                                res.load   = 1'b0;
                                state_next = ST_READ;
                            end
                            else
                            begin
                                res.rejected = 1'b1;
                            end
                        end
                        default:
                        begin
                            res.load = 1'b0;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                res.load     = 1'b1;
                res.from_ram = 1'b1;
                state_next   = ST_RUN;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase

        res.col = POS_COL_W'(col_next) + 7'd1;
        res.row = POS_ROW_W'(line_next) + 6'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            col_reg   <= '0;
            line_reg  <= '0;
            sweep_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            line_reg  <= line_next;
            sweep_reg <= sweep_next;
        end
    end

endmodule

>>> sim/console_result_checker.sv
// Checker for the text console cell writer: predicts every result and compares it.
module console_result_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [tccw_pkg::COLOR_W-1:0]   cfg_data,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic [tccw_pkg::KIND_W-1:0]    kind,
    input  logic [tccw_pkg::CHAR_W-1:0]    char_code,
    input  logic [tccw_pkg::POS_COL_W-1:0] col_pos,
    input  logic [tccw_pkg::POS_ROW_W-1:0] row_pos,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [tccw_pkg::POS_COL_W-1:0] cursor_col,
    input  logic [tccw_pkg::POS_ROW_W-1:0] cursor_row,
    input  logic [tccw_pkg::CHAR_W-1:0]    cell_char,
    input  logic [tccw_pkg::COLOR_W-1:0]   cell_color,
    input  logic                           rejected,
    output int                             fail_count,
    output int                             pending,
    output int                             results_checked,
    output int                             rejects_seen
);
    import tccw_pkg::*;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [CHAR_W-1:0]  code;
    } screen_cell_t;

    typedef struct packed {
        logic [POS_COL_W-1:0] col;
        logic [POS_ROW_W-1:0] row;
        logic [CHAR_W-1:0]    code;
        logic [COLOR_W-1:0]   color;
        logic                 rejected;
    } console_result_t;

    screen_cell_t      screen [CELLS];
    logic [COL_W-1:0]  cur_col;
    logic [LINE_W-1:0] cur_line;
    logic [COLOR_W-1:0] fg_color;
    console_result_t   expected_results [$];
    console_result_t   want;
    int                mismatches = 0;
    int                checked = 0;
    int                rejects = 0;

    function automatic void blank_screen();
        for (int i = 0; i < CELLS; i++)
        begin
            screen[i] = BLANK_CELL;
        end
        cur_col  = '0;
        cur_line = '0;
    endfunction

    function automatic logic position_in_range(logic [POS_COL_W-1:0] c,
                                               logic [POS_ROW_W-1:0] r);
        return c >= 1 && c <= COLUMNS && r >= 1 && r <= LINES;
    endfunction

    // Applies one transaction to the shadow screen and returns the result it must produce.
    function automatic console_result_t next_console_result(logic [KIND_W-1:0] k,
                                                            logic [CHAR_W-1:0] code,
                                                            logic [POS_COL_W-1:0] c,
                                                            logic [POS_ROW_W-1:0] r);
        console_result_t res;
        screen_cell_t    hit;
        res = '0;
        case (k)
            KIND_PUT:
            begin
                if (code == NUL_CODE)
                begin
                    code = SPACE_CODE;
                end
                if (code == NEWLINE_CODE)
                begin
                    cur_col = '0;
                    if (cur_line != LINE_W'(LINES - 1))
                    begin
                        cur_line++;
                    end
                end
                else
                begin
                    screen[int'(cur_line) * COLUMNS + int'(cur_col)] = {fg_color, code};
                    // The last column wraps to the next row; the very last cell sticks.
                    if (cur_col != COL_W'(COLUMNS - 1))
                    begin
                        cur_col++;
                    end
                    else if (cur_line != LINE_W'(LINES - 1))
                    begin
                        cur_line++;
                        cur_col = '0;
                    end
                end
            end
            KIND_MOVE:
            begin
                if (position_in_range(c, r))
                begin
                    cur_col  = COL_W'(c - 1);
                    cur_line = LINE_W'(r - 1);
                end
                else
                begin
                    res.rejected = 1'b1;
                end
            end
            KIND_CLEAR:
            begin
                blank_screen();
            end
            default:
            begin
                if (position_in_range(c, r))
                begin
                    hit       = screen[(int'(r) - 1) * COLUMNS + int'(c) - 1];
                    res.code  = hit.code;
                    res.color = hit.color;
                end
                else
                begin
                    res.rejected = 1'b1;
                end
            end
        endcase
        res.col = POS_COL_W'(cur_col) + 1'b1;
        res.row = POS_ROW_W'(cur_line) + 1'b1;
        return res;
    endfunction

    task automatic check_field(string field, int unsigned exp_val, int unsigned act_val);
        if (exp_val != act_val)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, exp_val, act_val);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_color = COLOR_RESET;
            blank_screen();
            expected_results.delete();
        end
        else
        begin
            // The result leaving now belongs to an earlier transaction, so it is checked
            // before the transaction accepted at this edge is queued.
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result with no transaction pending, col %0d row %0d",
                             $time, cursor_col, cursor_row);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("cursor_col", 32'(want.col), 32'(cursor_col));
                    check_field("cursor_row", 32'(want.row), 32'(cursor_row));
                    check_field("cell_char", 32'(want.code), 32'(cell_char));
                    check_field("cell_color", 32'(want.color), 32'(cell_color));
                    check_field("rejected", 32'(want.rejected), 32'(rejected));
                    checked++;
                    if (want.rejected)
                    begin
                        rejects++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                expected_results.push_back(
                    next_console_result(kind, char_code, col_pos, row_pos));
            end
            if (cfg_valid && cfg_ready)
            begin
                fg_color = cfg_data;
            end
        end
        fail_count      <= mismatches;
        pending         <= expected_results.size();
        results_checked <= checked;
        rejects_seen    <= rejects;
    end

endmodule

>>> sim/tb_text_console_cell_writer_core.sv
// Testbench top for the text console cell writer: stimulus, flow control and verdict.
module tb_text_console_cell_writer_core;
    import tccw_pkg::*;

    localparam int CYCLE_LIMIT      = 400000;
    localparam int RANDOM_PER_PHASE = 450;
    localparam int SETTLE_CYCLES    = 16;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [COLOR_W-1:0]   cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic [KIND_W-1:0]    kind = KIND_PUT;
    logic [CHAR_W-1:0]    char_code = '0;
    logic [POS_COL_W-1:0] col_pos = '0;
    logic [POS_ROW_W-1:0] row_pos = '0;
    logic                 out_ready = 1'b0;

    logic                 cfg_ready;
    logic                 in_ready;
    logic                 out_valid;
    logic [POS_COL_W-1:0] cursor_col;
    logic [POS_ROW_W-1:0] cursor_row;
    logic [CHAR_W-1:0]    cell_char;
    logic [COLOR_W-1:0]   cell_color;
    logic                 rejected;

    int fail_count;
    int pending;
    int results_checked;
    int rejects_seen;

    int send_idle_pct = 34;
    int recv_idle_pct = 87;
    int cycle_count = 0;
    int puts_sent = 0;
    int moves_sent = 0;
    int clears_sent = 0;
    int reads_sent = 0;
    logic [COLOR_W-1:0] last_color;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    text_console_cell_writer_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .char_code  (char_code),
        .col_pos    (col_pos),
        .row_pos    (row_pos),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .cursor_col (cursor_col),
        .cursor_row (cursor_row),
        .cell_char  (cell_char),
        .cell_color (cell_color),
        .rejected   (rejected)
    );

    console_result_checker result_chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .kind            (kind),
        .char_code       (char_code),
        .col_pos         (col_pos),
        .row_pos         (row_pos),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .cursor_col      (cursor_col),
        .cursor_row      (cursor_row),
        .cell_char       (cell_char),
        .cell_color      (cell_color),
        .rejected        (rejected),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked),
        .rejects_seen    (rejects_seen)
    );

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results pending",
                     cycle_count, pending);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Valid is left high after acceptance so back-to-back transactions need only one
    // assignment per edge; the idle loop or the drain lowers it.
    task automatic send_item(logic [KIND_W-1:0] k, logic [CHAR_W-1:0] code,
                             logic [POS_COL_W-1:0] c, logic [POS_ROW_W-1:0] r);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= k;
        char_code <= code;
        col_pos   <= c;
        row_pos   <= r;
        do
            @(posedge clk);
        while (!in_ready);
        case (k)
            KIND_PUT:   puts_sent++;
            KIND_MOVE:  moves_sent++;
            KIND_CLEAR: clears_sent++;
            default:    reads_sent++;
        endcase
    endtask

    task automatic write_color(logic [COLOR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Legal 1-based position, weighted toward the screen edges.
    function automatic logic [POS_COL_W+POS_ROW_W-1:0] legal_position();
        logic [POS_COL_W-1:0] c;
        logic [POS_ROW_W-1:0] r;
        int roll;
        roll = $urandom_range(0, 99);
        c = (roll < 25) ? POS_COL_W'(COLUMNS) :
            (roll < 35) ? POS_COL_W'(1) :
            (roll < 45) ? POS_COL_W'($urandom_range(COLUMNS - 4, COLUMNS)) :
                          POS_COL_W'($urandom_range(1, COLUMNS));
        roll = $urandom_range(0, 99);
        r = (roll < 25) ? POS_ROW_W'(LINES) :
            (roll < 35) ? POS_ROW_W'(1) :
                          POS_ROW_W'($urandom_range(1, LINES));
        return {c, r};
    endfunction

    task automatic run_random_phase(int count);
        logic [KIND_W-1:0]    k;
        logic [CHAR_W-1:0]    code;
        logic [POS_COL_W-1:0] c;
        logic [POS_ROW_W-1:0] r;
        int pick;
        int roll;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            roll = $urandom_range(0, 99);
            code = CHAR_W'($urandom_range(0, 255));
            c    = POS_COL_W'($urandom_range(0, 127));
            r    = POS_ROW_W'($urandom_range(0, 63));
            if (pick < 58)
            begin
                k = KIND_PUT;
                if (roll < 12)
                begin
                    code = NEWLINE_CODE;
                end
                else if (roll < 16)
                begin
                    code = NUL_CODE;
                end
            end
            else if (pick < 73)
            begin
                k = KIND_MOVE;
                if (roll < 85)
                begin
                    {c, r} = legal_position();
                end
            end
            else if (pick < 74)
            begin
                k = KIND_CLEAR;
            end
            else
            begin
                k = KIND_READ;
                if (roll < 85)
                begin
                    {c, r} = legal_position();
                end
            end
            send_item(k, code, c, r);
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, run with the reset foreground color.
        send_item(KIND_READ, 8'h00, 7'd1, 6'd1);
        send_item(KIND_PUT, 8'h41, 7'd0, 6'd0);
        send_item(KIND_PUT, NUL_CODE, 7'd0, 6'd0);
        send_item(KIND_PUT, 8'hFF, 7'd0, 6'd0);
        send_item(KIND_READ, 8'h00, 7'd1, 6'd1);
        send_item(KIND_READ, 8'h00, 7'd2, 6'd1);
        send_item(KIND_READ, 8'hFF, 7'd3, 6'd1);
        send_item(KIND_MOVE, 8'h00, 7'(COLUMNS), 6'd1);
        send_item(KIND_PUT, 8'h5A, 7'd0, 6'd0);
        send_item(KIND_MOVE, 8'h00, 7'(COLUMNS), 6'(LINES));
        send_item(KIND_PUT, 8'h7E, 7'd0, 6'd0);
        send_item(KIND_PUT, 8'h80, 7'd0, 6'd0);
        send_item(KIND_READ, 8'h00, 7'(COLUMNS), 6'(LINES));
        send_item(KIND_PUT, NEWLINE_CODE, 7'd0, 6'd0);
        send_item(KIND_MOVE, 8'h00, 7'd1, 6'd1);
        send_item(KIND_PUT, NEWLINE_CODE, 7'd0, 6'd0);
        send_item(KIND_MOVE, 8'h00, 7'd0, 6'd5);
        send_item(KIND_MOVE, 8'h00, 7'(COLUMNS + 1), 6'd1);
        send_item(KIND_MOVE, 8'h00, 7'd1, 6'(LINES + 1));
        send_item(KIND_MOVE, 8'h00, 7'd127, 6'd63);
        send_item(KIND_READ, 8'h00, 7'd0, 6'd0);
        send_item(KIND_READ, 8'h00, 7'(COLUMNS), 6'(LINES + 1));
        send_item(KIND_CLEAR, 8'h00, 7'd0, 6'd0);
        send_item(KIND_READ, 8'h00, 7'(COLUMNS), 6'(LINES));
        send_item(KIND_PUT, 8'h01, 7'd0, 6'd0);
        wait_drained();

        write_color(4'd0);
        run_random_phase(RANDOM_PER_PHASE);
        wait_drained();

        send_idle_pct = 87;
        recv_idle_pct = 34;
        write_color(4'd15);
        run_random_phase(RANDOM_PER_PHASE);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        last_color = COLOR_W'($urandom_range(1, 14));
        write_color(last_color);
        run_random_phase(RANDOM_PER_PHASE);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d puts, %0d moves, %0d clears and %0d reads; %0d results checked.",
                 puts_sent, moves_sent, clears_sent, reads_sent, results_checked);
        $display("%0d rejected positions; foreground colors 7, 0, 15 and %0d; %0d mismatches.",
                 rejects_seen, last_color, fail_count);
        if (fail_count == 0 && pending == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
src/tccw_pkg.sv
src/tccw_cell_ram.sv
src/tccw_ctrl.sv
src/text_console_cell_writer_core.sv
sim/console_result_checker.sv
sim/tb_text_console_cell_writer_core.sv
